/* hw/rtl/ifc_pkg.sv */
package ifc_pkg;

    localparam int CANVAS_COLS_DEFAULT = 256;
    localparam int CANVAS_ROWS_DEFAULT = 256;

    localparam int IDX_W     = 8;
    localparam int POS_W     = 8;
    localparam int SIZE_W    = 9;
    localparam int MODE_W    = 3;
    localparam int TRANSP_W  = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;
    localparam int DIM_W     = 13;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND   = 3'd6;

    localparam logic [1:0] DISPOSE_NONE       = 2'd0;
    localparam logic [1:0] DISPOSE_BACKGROUND = 2'd1;

    localparam logic [SIZE_W-1:0]   FRAME_SIZE_RESET  = 9'd256;
    localparam logic [TRANSP_W-1:0] TRANSPARENT_RESET = 9'h1FF;

    typedef struct packed {
        logic [POS_W-1:0]    frame_left;
        logic [POS_W-1:0]    frame_top;
        logic [SIZE_W-1:0]   frame_width;
        logic [SIZE_W-1:0]   frame_height;
        logic [MODE_W-1:0]   frame_mode;
        logic [TRANSP_W-1:0] transparent_index;
        logic [IDX_W-1:0]    background_index;
    } cfg_t;

    typedef struct packed {
        logic             on_canvas;
        logic             in_rect;
        logic             take_new;
        logic [IDX_W-1:0] pixel;
        logic             last;
    } item_t;

endpackage

/* hw/rtl/ifc_pixel_if.sv */
interface ifc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] canvas_col;
    logic [7:0] canvas_row;
    logic [7:0] frame_pixel;
    logic       frame_end;

    modport source (output valid, output canvas_col, output canvas_row,
                    output frame_pixel, output frame_end, input ready);
    modport sink (input valid, input canvas_col, input canvas_row,
                  input frame_pixel, input frame_end, output ready);
endinterface

/* hw/rtl/ifc_shown_if.sv */
interface ifc_shown_if;
    logic       valid;
    logic       ready;
    logic [7:0] shown_index;
    logic       shown_last;

    modport source (output valid, output shown_index, output shown_last, input ready);
    modport sink (input valid, input shown_index, input shown_last, output ready);
endinterface

/* hw/rtl/ifc_cfg_if.sv */
interface ifc_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ifc_front.sv */
module ifc_front #(
    parameter int CANVAS_COLS = ifc_pkg::CANVAS_COLS_DEFAULT,
    parameter int CANVAS_ROWS = ifc_pkg::CANVAS_ROWS_DEFAULT,
    parameter int COL_W       = 8,
    parameter int ROW_W       = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    ifc_pixel_if.sink                in_ch,
    input  ifc_pkg::cfg_t            cfg,
    output logic                     push_valid,
    input  logic                     push_ready,
    output ifc_pkg::item_t           push_item,
    output logic [COL_W+ROW_W-1:0]   push_addr
);

    logic                         valid_reg;
    logic                         valid_next;
    ifc_pkg::item_t               item_reg;
    logic [COL_W+ROW_W-1:0]       addr_reg;

    ifc_pkg::item_t               item_next;
    logic [COL_W+ROW_W-1:0]       addr_next;
    logic [COL_W+7:0]             col_wide;
    logic [ROW_W+7:0]             row_wide;
    logic                         on_canvas;
    logic                         col_hit;
    logic                         row_hit;
    logic                         in_rect;
    logic                         see_through;
    logic                         accept;

    assign in_ch.ready = !valid_reg || push_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        col_wide  = {{COL_W{1'b0}}, in_ch.canvas_col};
        row_wide  = {{ROW_W{1'b0}}, in_ch.canvas_row};
        on_canvas = ({5'd0, in_ch.canvas_col} < ifc_pkg::DIM_W'(CANVAS_COLS))
                 && ({5'd0, in_ch.canvas_row} < ifc_pkg::DIM_W'(CANVAS_ROWS));
        col_hit   = ({2'b0, in_ch.canvas_col} >= {2'b0, cfg.frame_left})
                 && ({2'b0, in_ch.canvas_col}
                     < ({2'b0, cfg.frame_left} + {1'b0, cfg.frame_width}));
        row_hit   = ({2'b0, in_ch.canvas_row} >= {2'b0, cfg.frame_top})
                 && ({2'b0, in_ch.canvas_row}
                     < ({2'b0, cfg.frame_top} + {1'b0, cfg.frame_height}));
        in_rect   = on_canvas && col_hit && row_hit;
        see_through = cfg.frame_mode[0] && !cfg.transparent_index[8]
                   && (in_ch.frame_pixel == cfg.transparent_index[7:0]);

        item_next.on_canvas = on_canvas;
        item_next.in_rect   = in_rect;
        item_next.take_new  = in_rect && !see_through;
        item_next.pixel     = in_ch.frame_pixel;
        item_next.last      = in_ch.frame_end;
        addr_next = {row_wide[ROW_W-1:0], col_wide[COL_W-1:0]};

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
            addr_reg <= addr_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;
    assign push_addr  = addr_reg;

endmodule

/* hw/rtl/ifc_queue.sv */
module ifc_queue #(
    parameter int ADDR_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  ifc_pkg::item_t       push_item,
    input  logic [ADDR_W-1:0]    push_addr,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output ifc_pkg::item_t       pop_item,
    output logic [ADDR_W-1:0]    pop_addr
);

    localparam int PTR_W = $clog2(ifc_pkg::QUEUE_DEPTH);

    ifc_pkg::item_t       item_mem [ifc_pkg::QUEUE_DEPTH];
    logic [ADDR_W-1:0]    addr_mem [ifc_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [PTR_W:0]       count_reg;
    logic [PTR_W:0]       count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(ifc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = item_mem[rd_ptr_reg];
    assign pop_addr   = addr_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            item_mem[wr_ptr_reg] <= push_item;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

endmodule

/* hw/rtl/ifc_back.sv */
module ifc_back #(
    parameter int ADDR_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ifc_pkg::cfg_t        cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  ifc_pkg::item_t       pop_item,
    input  logic [ADDR_W-1:0]    pop_addr,
    ifc_shown_if.source          out_ch
);

    logic [ifc_pkg::IDX_W-1:0]  canvas_mem [2**ADDR_W];

    logic                       stage_valid_reg;
    logic                       stage_valid_next;
    ifc_pkg::item_t             stage_item_reg;
    logic [ADDR_W-1:0]          stage_addr_reg;
    logic [ifc_pkg::IDX_W-1:0]  rdata_reg;
    logic                       fwd_reg;
    logic [ifc_pkg::IDX_W-1:0]  fwd_data_reg;
    logic                       canvas_ready_reg;
    logic                       canvas_ready_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [ifc_pkg::IDX_W-1:0]  out_index_reg;
    logic                       out_last_reg;

    logic                       out_adv;
    logic                       stage_adv;
    logic                       do_pop;
    logic [ifc_pkg::IDX_W-1:0]  kept;
    logic [ifc_pkg::IDX_W-1:0]  base;
    logic [ifc_pkg::IDX_W-1:0]  shown;
    logic [ifc_pkg::IDX_W-1:0]  store;
    logic                       hazard;

    assign out_adv   = !out_valid_reg || out_ch.ready;
    assign stage_adv = stage_valid_reg && out_adv;
    assign pop_ready = !stage_valid_reg || out_adv;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        kept  = fwd_reg ? fwd_data_reg : rdata_reg;
        base  = (stage_item_reg.on_canvas && canvas_ready_reg) ? kept
              : cfg.background_index;
        shown = stage_item_reg.take_new ? stage_item_reg.pixel : base;
        unique case (cfg.frame_mode[2:1])
            ifc_pkg::DISPOSE_NONE:       store = shown;
            ifc_pkg::DISPOSE_BACKGROUND: store = stage_item_reg.in_rect
                                               ? cfg.background_index : base;
            default:                     store = base;
        endcase

        // A beat entering now reads the address the leaving beat writes.
        hazard = stage_adv && stage_item_reg.on_canvas && (stage_addr_reg == pop_addr);

        if (do_pop)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_adv)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end

        canvas_ready_next = canvas_ready_reg || (stage_adv && stage_item_reg.last);

        if (stage_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            canvas_ready_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            canvas_ready_reg <= canvas_ready_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            stage_item_reg <= pop_item;
            stage_addr_reg <= pop_addr;
            rdata_reg      <= canvas_mem[pop_addr];
            fwd_reg        <= hazard;
            fwd_data_reg   <= store;
        end
        if (stage_adv)
        begin
            out_index_reg <= shown;
            out_last_reg  <= stage_item_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv && stage_item_reg.on_canvas)
        begin
            canvas_mem[stage_addr_reg] <= store;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.shown_index = out_index_reg;
    assign out_ch.shown_last  = out_last_reg;

endmodule

/* hw/rtl/indexed_frame_compositor_core.sv */
// Channel   Direction  Beat contents
// in_ch     sink       canvas_col, canvas_row, frame_pixel, frame_end
// out_ch    source     shown_index, shown_last
// cfg       sink       index (register number), data
//
// One beat is accepted per cycle while out_ch is not stalled, and each input beat yields one output beat.
// A beat passes through the front register, the queue, the canvas read stage and the output register.
// The canvas memory takes one read and one write per cycle; a read that meets the
// write of the previous beat at the same position is forwarded.
// Reset clears control state only; the canvas is undefined until a frame writes it.
// A stalled output fills the queue, after which in_ch.ready falls.
module indexed_frame_compositor_core #(
    parameter int CANVAS_COLS = ifc_pkg::CANVAS_COLS_DEFAULT,
    parameter int CANVAS_ROWS = ifc_pkg::CANVAS_ROWS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    ifc_pixel_if.sink   in_ch,
    ifc_shown_if.source out_ch,
    ifc_cfg_if.sink     cfg
);

    localparam int COL_W  = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
    localparam int ROW_W  = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int ADDR_W = COL_W + ROW_W;

    ifc_pkg::cfg_t         cfg_reg;
    ifc_pkg::cfg_t         cfg_next;

    logic                  push_valid;
    logic                  push_ready;
    ifc_pkg::item_t        push_item;
    logic [ADDR_W-1:0]     push_addr;
    logic                  pop_valid;
    logic                  pop_ready;
    ifc_pkg::item_t        pop_item;
    logic [ADDR_W-1:0]     pop_addr;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                ifc_pkg::REG_FRAME_LEFT:   cfg_next.frame_left        = cfg.data[7:0];
                ifc_pkg::REG_FRAME_TOP:    cfg_next.frame_top         = cfg.data[7:0];
                ifc_pkg::REG_FRAME_WIDTH:  cfg_next.frame_width       = cfg.data;
                ifc_pkg::REG_FRAME_HEIGHT: cfg_next.frame_height      = cfg.data;
                ifc_pkg::REG_FRAME_MODE:   cfg_next.frame_mode        = cfg.data[2:0];
                ifc_pkg::REG_TRANSPARENT:  cfg_next.transparent_index = cfg.data;
                ifc_pkg::REG_BACKGROUND:   cfg_next.background_index  = cfg.data[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_left        <= '0;
            cfg_reg.frame_top         <= '0;
            cfg_reg.frame_width       <= ifc_pkg::FRAME_SIZE_RESET;
            cfg_reg.frame_height      <= ifc_pkg::FRAME_SIZE_RESET;
            cfg_reg.frame_mode        <= '0;
            cfg_reg.transparent_index <= ifc_pkg::TRANSPARENT_RESET;
            cfg_reg.background_index  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ifc_front #(
        .CANVAS_COLS (CANVAS_COLS),
        .CANVAS_ROWS (CANVAS_ROWS),
        .COL_W       (COL_W),
        .ROW_W       (ROW_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .push_addr  (push_addr)
    );

    ifc_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .push_addr  (push_addr),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .pop_addr   (pop_addr)
    );

    ifc_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .pop_addr  (pop_addr),
        .out_ch    (out_ch)
    );

endmodule
